// ===== design/hrg_pkg.sv =====
// shared types, register codes and reset values for the hsv to rgb converter
package hrg_pkg;

	// input item
	typedef struct packed {
		logic [15:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  level;
		logic        enhanced;
	} in_t;

	// result item
	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] red_ticks;
		logic [15:0] green_ticks;
		logic [15:0] blue_ticks;
	} out_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_HUE_MAX      = 2'd0,
		CFG_ENH_HUE_MAX  = 2'd1,
		CFG_MAX_LEVEL    = 2'd2,
		CFG_PERIOD_TICKS = 2'd3
	} cfg_idx_t;

	// hue sectors of 60 degrees
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	localparam logic [15:0] HUE_MAX_RST      = 16'd254;
	localparam logic [15:0] ENH_HUE_MAX_RST  = 16'd65535;
	localparam logic [7:0]  MAX_LEVEL_RST    = 8'd254;
	localparam logic [15:0] PERIOD_TICKS_RST = 16'd3333;

	localparam logic [8:0]  DEG_FULL   = 9'd360;
	localparam logic [15:0] DEG_SECTOR = 16'd60;
	localparam logic [7:0]  LVL_FULL   = 8'd255;

	// hue dividend and divisor widths
	localparam int HUE_NUM_W = 25;
	localparam int HUE_DEN_W = 16;
	// gamma divider widths
	localparam int GAM_NUM_W = 16;
	// tick divider widths
	localparam int TCK_NUM_W = 32;
	localparam int LVL_W     = 8;

endpackage

// ===== design/hrg_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
module hrg_div #(
	parameter int NUM_W  = 16,
	parameter int DEN_W  = 8,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quot,
	output logic [SIDE_W-1:0] side_out
);

	logic              v_s  [NUM_W];
	logic [NUM_W-1:0]  w_s  [NUM_W];
	logic [DEN_W-1:0]  r_s  [NUM_W];
	logic [DEN_W-1:0]  d_s  [NUM_W];
	logic [SIDE_W-1:0] sd_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic              src_v;
		logic [NUM_W-1:0]  src_w;
		logic [DEN_W-1:0]  src_r;
		logic [DEN_W-1:0]  src_d;
		logic [SIDE_W-1:0] src_sd;
		logic [DEN_W:0]    part;
		logic              ge;
		logic [DEN_W:0]    diff;

		// stage source: ports or previous stage
		if (i == 0) begin : g_first
			assign src_v  = in_valid;
			assign src_w  = num;
			assign src_r  = '0;
			assign src_d  = den;
			assign src_sd = side_in;
		end else begin : g_next
			assign src_v  = v_s[i-1];
			assign src_w  = w_s[i-1];
			assign src_r  = r_s[i-1];
			assign src_d  = d_s[i-1];
			assign src_sd = sd_s[i-1];
		end

		// one trial subtract
		assign part = {src_r, src_w[NUM_W-1]};
		assign ge   = part >= {1'b0, src_d};
		assign diff = part - {1'b0, src_d};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				w_s[i]  <= {src_w[NUM_W-2:0], ge};
				r_s[i]  <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
				d_s[i]  <= src_d;
				sd_s[i] <= src_sd;
			end
		end
	end

	assign out_valid = v_s[NUM_W-1];
	assign quot      = w_s[NUM_W-1];
	assign side_out  = sd_s[NUM_W-1];

endmodule

// ===== design/hrg_color.sv =====
// sector, remainder and p/q/t terms down to rgb and squared channels
module hrg_color (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [15:0] deg,
	input  logic [7:0]  sat,
	input  logic [7:0]  val,
	output logic        out_valid,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [15:0] red_sq,
	output logic [15:0] green_sq,
	output logic [15:0] blue_sq
);

	logic               v_s2, v_s3, v_s4, v_s5;
	hrg_pkg::sector_t   sec_s2, sec_s3, sec_s4;
	logic [7:0]         rem_s2;
	logic [7:0]         sat_s2, val_s2, val_s3, val_s4;
	logic               grey_s3, grey_s4;
	logic [7:0]         ns_s3, sr_s3, st_s3;
	logic [7:0]         p_s4, q_s4, t_s4;
	logic [7:0]         r_s5, g_s5, b_s5;
	logic [15:0]        rsq_s5, gsq_s5, bsq_s5;

	hrg_pkg::sector_t   sec_c;
	logic [15:0]        base_c;
	logic [15:0]        off_c;
	logic [7:0]         rem_c;
	logic [15:0]        sr_c, st_c, p_c, q_c, t_c;
	logic [7:0]         r_c, g_c, b_c;

	// sector by threshold compare
	always_comb begin
		if (deg >= {7'd0, hrg_pkg::DEG_FULL}) begin
			sec_c  = hrg_pkg::SEC_RED_YEL;
			base_c = '0;
		end else if (deg >= 16'd300) begin
			sec_c  = hrg_pkg::SEC_MAG_RED;
			base_c = 16'd300;
		end else if (deg >= 16'd240) begin
			sec_c  = hrg_pkg::SEC_BLU_MAG;
			base_c = 16'd240;
		end else if (deg >= 16'd180) begin
			sec_c  = hrg_pkg::SEC_CYN_BLU;
			base_c = 16'd180;
		end else if (deg >= 16'd120) begin
			sec_c  = hrg_pkg::SEC_GRN_CYN;
			base_c = 16'd120;
		end else if (deg >= hrg_pkg::DEG_SECTOR) begin
			sec_c  = hrg_pkg::SEC_YEL_GRN;
			base_c = hrg_pkg::DEG_SECTOR;
		end else begin
			sec_c  = hrg_pkg::SEC_RED_YEL;
			base_c = '0;
		end
		// at or beyond full circle the whole degree value is the offset
		off_c = deg - base_c;
		rem_c = {off_c[5:0], 2'b00};
	end

	// fractional products
	assign sr_c = sat_s2 * rem_s2;
	assign st_c = sat_s2 * (hrg_pkg::LVL_FULL - rem_s2);

	// p, q and t terms
	assign p_c = val_s3 * ns_s3;
	assign q_c = val_s3 * (hrg_pkg::LVL_FULL - sr_s3);
	assign t_c = val_s3 * (hrg_pkg::LVL_FULL - st_s3);

	// channel selection
	always_comb begin
		if (grey_s4) begin
			r_c = val_s4; g_c = val_s4; b_c = val_s4;
		end else begin
			case (sec_s4)
				hrg_pkg::SEC_RED_YEL: begin
					r_c = val_s4; g_c = t_s4; b_c = p_s4;
				end
				hrg_pkg::SEC_YEL_GRN: begin
					r_c = q_s4; g_c = val_s4; b_c = p_s4;
				end
				hrg_pkg::SEC_GRN_CYN: begin
					r_c = p_s4; g_c = val_s4; b_c = t_s4;
				end
				hrg_pkg::SEC_CYN_BLU: begin
					r_c = p_s4; g_c = q_s4; b_c = val_s4;
				end
				hrg_pkg::SEC_BLU_MAG: begin
					r_c = t_s4; g_c = p_s4; b_c = val_s4;
				end
				default: begin
					r_c = val_s4; g_c = p_s4; b_c = q_s4;
				end
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			sec_s2  <= sec_c;
			rem_s2  <= rem_c;
			sat_s2  <= sat;
			val_s2  <= val;
			sec_s3  <= sec_s2;
			val_s3  <= val_s2;
			grey_s3 <= sat_s2 == 8'd0;
			ns_s3   <= hrg_pkg::LVL_FULL - sat_s2;
			sr_s3   <= sr_c[15:8];
			st_s3   <= st_c[15:8];
			sec_s4  <= sec_s3;
			val_s4  <= val_s3;
			grey_s4 <= grey_s3;
			p_s4    <= p_c[15:8];
			q_s4    <= q_c[15:8];
			t_s4    <= t_c[15:8];
			r_s5    <= r_c;
			g_s5    <= g_c;
			b_s5    <= b_c;
			rsq_s5  <= r_c * r_c;
			gsq_s5  <= g_c * g_c;
			bsq_s5  <= b_c * b_c;
		end
	end

	assign out_valid = v_s5;
	assign red       = r_s5;
	assign green     = g_s5;
	assign blue      = b_s5;
	assign red_sq    = rsq_s5;
	assign green_sq  = gsq_s5;
	assign blue_sq   = bsq_s5;

endmodule

// ===== design/hrg_chan.sv =====
// per-channel gamma divide, period scaling and tick divide
module hrg_chan (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [7:0]  color,
	input  logic [15:0] color_sq,
	input  logic [7:0]  level_div,
	input  logic [15:0] period,
	output logic        out_valid,
	output logic [7:0]  color_out,
	output logic [15:0] ticks
);

	logic                               gv;
	logic [hrg_pkg::GAM_NUM_W-1:0]      gq;
	logic [7:0]                         gc;
	logic                               v_s6;
	logic [hrg_pkg::TCK_NUM_W-1:0]      prod_s6;
	logic [7:0]                         c_s6;
	logic [hrg_pkg::TCK_NUM_W-1:0]      tq;

	// gamma: square over max level
	hrg_div #(
		.NUM_W  (hrg_pkg::GAM_NUM_W),
		.DEN_W  (hrg_pkg::LVL_W),
		.SIDE_W (8)
	) u_gam (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.num       (color_sq),
		.den       (level_div),
		.side_in   (color),
		.out_valid (gv),
		.quot      (gq),
		.side_out  (gc)
	);

	// scale by period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= gv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s6 <= gq * period;
			c_s6    <= gc;
		end
	end

	// ticks: product over max level
	hrg_div #(
		.NUM_W  (hrg_pkg::TCK_NUM_W),
		.DEN_W  (hrg_pkg::LVL_W),
		.SIDE_W (8)
	) u_tck (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (prod_s6),
		.den       (level_div),
		.side_in   (c_s6),
		.out_valid (out_valid),
		.quot      (tq),
		.side_out  (color_out)
	);

	assign ticks = tq[15:0];

endmodule

// ===== design/hsv_to_rgb_gamma_pwm.sv =====
// hsv to rgb converter with square-law gamma and pwm tick scaling
// pipeline: input register, hue divide, color stages, gamma divide, period scale
//   and tick divide, in that order; the dividers resolve one quotient bit per stage
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// reset: arst_n clears all valid bits and loads the register reset values
module hsv_to_rgb_gamma_pwm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  hrg_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output hrg_pkg::out_t  out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [1:0]     cfg_index,
	input  logic [15:0]    cfg_data
);

	logic [15:0] hue_max_q, enh_hue_max_q, period_q;
	logic [7:0]  max_level_q;
	logic        en;
	logic        in_acc;

	logic                             v_s1;
	logic [hrg_pkg::HUE_NUM_W-1:0]    num_s1;
	logic [hrg_pkg::HUE_DEN_W-1:0]    den_s1;
	logic [7:0]                       sat_s1, val_s1;
	logic [15:0]                      hden_c;
	logic [7:0]                       lvl_div;

	logic                             dv;
	logic [hrg_pkg::HUE_NUM_W-1:0]    dq;
	logic [15:0]                      dside;

	logic        cv;
	logic [7:0]  cr, cg, cb;
	logic [15:0] crsq, cgsq, cbsq;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_max_q     <= hrg_pkg::HUE_MAX_RST;
			enh_hue_max_q <= hrg_pkg::ENH_HUE_MAX_RST;
			max_level_q   <= hrg_pkg::MAX_LEVEL_RST;
			period_q      <= hrg_pkg::PERIOD_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (hrg_pkg::cfg_idx_t'(cfg_index))
				hrg_pkg::CFG_HUE_MAX:      hue_max_q     <= cfg_data;
				hrg_pkg::CFG_ENH_HUE_MAX:  enh_hue_max_q <= cfg_data;
				hrg_pkg::CFG_MAX_LEVEL:    max_level_q   <= cfg_data[7:0];
				hrg_pkg::CFG_PERIOD_TICKS: period_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances unless the result is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign in_acc   = in_valid && !in_stall;

	// zero divisors act as one
	always_comb begin
		hden_c = in_data.enhanced ? enh_hue_max_q : hue_max_q;
		if (hden_c == 16'd0) begin
			hden_c = 16'd1;
		end
		lvl_div = (max_level_q == 8'd0) ? 8'd1 : max_level_q;
	end

	// stage 1: hue times full circle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= in_data.hue * hrg_pkg::DEG_FULL;
			den_s1 <= hden_c;
			sat_s1 <= in_data.saturation;
			val_s1 <= in_data.level;
		end
	end

	// hue to degrees
	hrg_div #(
		.NUM_W  (hrg_pkg::HUE_NUM_W),
		.DEN_W  (hrg_pkg::HUE_DEN_W),
		.SIDE_W (16)
	) u_hue (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.num       (num_s1),
		.den       (den_s1),
		.side_in   ({sat_s1, val_s1}),
		.out_valid (dv),
		.quot      (dq),
		.side_out  (dside)
	);

	hrg_color u_color (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv),
		.deg       (dq[15:0]),
		.sat       (dside[15:8]),
		.val       (dside[7:0]),
		.out_valid (cv),
		.red       (cr),
		.green     (cg),
		.blue      (cb),
		.red_sq    (crsq),
		.green_sq  (cgsq),
		.blue_sq   (cbsq)
	);

	// per-channel gamma and ticks
	hrg_chan u_red (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cv),
		.color     (cr),
		.color_sq  (crsq),
		.level_div (lvl_div),
		.period    (period_q),
		.out_valid (out_valid),
		.color_out (out_data.red),
		.ticks     (out_data.red_ticks)
	);

	hrg_chan u_green (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cv),
		.color     (cg),
		.color_sq  (cgsq),
		.level_div (lvl_div),
		.period    (period_q),
		.out_valid (),
		.color_out (out_data.green),
		.ticks     (out_data.green_ticks)
	);

	hrg_chan u_blue (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cv),
		.color     (cb),
		.color_sq  (cbsq),
		.level_div (lvl_div),
		.period    (period_q),
		.out_valid (),
		.color_out (out_data.blue),
		.ticks     (out_data.blue_ticks)
	);

`ifndef SYNTHESIS
	// input is held back only by a held result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// a dark channel gives no ticks
	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.red == 8'd0) |-> (out_data.red_ticks == 16'd0))
		else $error("dark red channel with nonzero ticks");

	// equal channels give equal ticks
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.red == out_data.green && out_data.green == out_data.blue)
		|-> (out_data.red_ticks == out_data.green_ticks
			&& out_data.green_ticks == out_data.blue_ticks))
		else $error("grey result with unequal ticks");
`endif

endmodule
